// ===== src/sida_pkg.sv =====
// ----------------------------------------------------------------------------
// sida_pkg
// shared types and constants for the signed integer to decimal text block
// ----------------------------------------------------------------------------
package sida_pkg;

  localparam int unsigned VALUE_W    = 32;
  localparam int unsigned DIGIT_W    = 4;
  localparam int unsigned NUM_DIGITS = 10;
  localparam int unsigned CHAR_W     = 8;

  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'd48;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'd45;

  typedef logic [DIGIT_W-1:0] digit_t;

  typedef struct packed {
    logic clear;
    logic shift;
  } cell_ctrl_t;

endpackage

// ===== src/signed_int_to_decimal_ascii.sv =====
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii
// converts a signed 32-bit word into its decimal ascii text, msd first
// ----------------------------------------------------------------------------
// channel  ports                               handshake
// input    start, busy, in_value[31:0]         taken when start && !busy
// output   out_valid, out_character, out_last  one-cycle strobe, no backpressure
//
// load the word, shift all 32 magnitude bits through a row of ten bcd cells,
// pass the sign state, then one digit per cycle
// the receiver cannot stall, characters leave at one per cycle
// rst_n is synchronous, active low, and returns the control to idle
// ----------------------------------------------------------------------------
module signed_int_to_decimal_ascii (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  logic signed [31:0]         in_value,
  output logic                       out_valid,
  output logic [7:0]                 out_character,
  output logic                       out_last
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_SIGN,
    ST_EMIT
  } state_t;

  localparam int unsigned IDX_W = $clog2(sida_pkg::NUM_DIGITS);
  localparam int unsigned CNT_W = $clog2(sida_pkg::VALUE_W);

  state_t                         state_r;
  logic [sida_pkg::VALUE_W-1:0]   mag_r;
  logic                           neg_r;
  logic [CNT_W-1:0]               cnt_r;
  logic [IDX_W-1:0]               idx_r;
  logic                           out_valid_r;
  logic [sida_pkg::CHAR_W-1:0]    out_character_r;
  logic                           out_last_r;

  sida_pkg::cell_ctrl_t           ctrl;
  sida_pkg::digit_t               digit_w [sida_pkg::NUM_DIGITS];
  logic                           chain_w [sida_pkg::NUM_DIGITS+1];
  logic [IDX_W-1:0]               msd;
  logic [sida_pkg::VALUE_W-1:0]   raw;
  logic                           accept;

  assign raw    = $unsigned(in_value);
  assign accept = start && (state_r == ST_IDLE);
  assign busy   = (state_r != ST_IDLE);

  assign ctrl.clear = accept;
  assign ctrl.shift = (state_r == ST_CONV);

  assign chain_w[0] = mag_r[sida_pkg::VALUE_W-1];

  for (genvar g = 0; g < sida_pkg::NUM_DIGITS; g++) begin : g_cell
    sida_bcd_cell u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .shift_in  (chain_w[g]),
      .shift_out (chain_w[g+1]),
      .digit     (digit_w[g])
    );
  end

  // most significant nonzero digit
  always_comb begin
    msd = '0;
    for (int i = 0; i < sida_pkg::NUM_DIGITS; i++) begin
      if (digit_w[i] != '0) begin
        msd = IDX_W'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      unique case (state_r)
        ST_IDLE: begin
          if (start) begin
            neg_r   <= raw[sida_pkg::VALUE_W-1];
            mag_r   <= raw[sida_pkg::VALUE_W-1] ? (~raw + 1'b1) : raw;
            cnt_r   <= '0;
            state_r <= ST_CONV;
          end
        end
        ST_CONV: begin
          mag_r <= {mag_r[sida_pkg::VALUE_W-2:0], 1'b0};
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == CNT_W'(sida_pkg::VALUE_W - 1)) begin
            state_r <= ST_SIGN;
          end
        end
        ST_SIGN: begin
          idx_r <= msd;
          if (neg_r) begin
            out_valid_r     <= 1'b1;
            out_character_r <= sida_pkg::CHAR_MINUS;
            out_last_r      <= 1'b0;
          end
          state_r <= ST_EMIT;
        end
        ST_EMIT: begin
          out_valid_r     <= 1'b1;
          out_character_r <= sida_pkg::CHAR_ZERO
                             + {{(sida_pkg::CHAR_W-sida_pkg::DIGIT_W){1'b0}}, digit_w[idx_r]};
          out_last_r      <= (idx_r == '0);
          idx_r           <= idx_r - 1'b1;
          if (idx_r == '0) begin
            state_r <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid     = out_valid_r;
  assign out_character = out_character_r;
  assign out_last      = out_last_r;

endmodule

// ===== src/sida_bcd_cell.sv =====
// ----------------------------------------------------------------------------
// sida_bcd_cell
// one decimal digit of the shift-add-3 chain, hands its top bit to the next
// ----------------------------------------------------------------------------
module sida_bcd_cell (
  input  logic                clk,
  input  sida_pkg::cell_ctrl_t ctrl,
  input  logic                shift_in,
  output logic                shift_out,
  output sida_pkg::digit_t    digit
);

  sida_pkg::digit_t digit_r;
  sida_pkg::digit_t digit_nxt;
  sida_pkg::digit_t adj;

  always_comb begin
    if (digit_r >= sida_pkg::digit_t'(5)) begin
      adj = digit_r + sida_pkg::digit_t'(3);
    end else begin
      adj = digit_r;
    end
    shift_out = adj[sida_pkg::DIGIT_W-1];
    if (ctrl.clear) begin
      digit_nxt = '0;
    end else if (ctrl.shift) begin
      digit_nxt = {adj[sida_pkg::DIGIT_W-2:0], shift_in};
    end else begin
      digit_nxt = digit_r;
    end
  end

  always_ff @(posedge clk) begin
    digit_r <= digit_nxt;
  end

  assign digit = digit_r;

endmodule

// ===== test/signed_int_to_decimal_ascii_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii_test
// self-checking bench for the signed integer to decimal ascii converter
// ----------------------------------------------------------------------------
module signed_int_to_decimal_ascii_test;

  localparam int NUM_RANDOM  = 440;
  localparam int CALM_TAIL   = 60;
  localparam int QUIET_LIMIT = 2000;
  localparam int DRAIN_WAIT  = 60;

  typedef struct packed {
    logic [sida_pkg::CHAR_W-1:0] character;
    logic                        last;
  } text_char_t;

  class decimal_text_board;
    text_char_t expected_chars[$];
    int         errors = 0;

    task report(string what);
      $display("mismatch: %s", what);
      errors++;
    endtask

    function void note_word(logic [sida_pkg::VALUE_W-1:0] raw);
      logic [sida_pkg::VALUE_W-1:0] mag;
      sida_pkg::digit_t             digs[sida_pkg::NUM_DIGITS];
      int                           nd;
      text_char_t                   c;
      mag = raw[sida_pkg::VALUE_W-1] ? (32'd0 - raw) : raw;
      nd  = 0;
      do begin
        digs[nd] = sida_pkg::digit_t'(mag % 32'd10);
        nd++;
        mag = mag / 32'd10;
      end while (mag != 0 && nd < sida_pkg::NUM_DIGITS);
      if (raw[sida_pkg::VALUE_W-1]) begin
        c.character = sida_pkg::CHAR_MINUS;
        c.last      = 1'b0;
        expected_chars.push_back(c);
      end
      for (int k = nd - 1; k >= 0; k--) begin
        c.character = sida_pkg::CHAR_ZERO
                      + {{(sida_pkg::CHAR_W-sida_pkg::DIGIT_W){1'b0}}, digs[k]};
        c.last      = (k == 0);
        expected_chars.push_back(c);
      end
    endfunction

    task check_char(logic [sida_pkg::CHAR_W-1:0] character, logic last);
      text_char_t want;
      if (expected_chars.size() == 0) begin
        report($sformatf("unexpected character 0x%02h last %0b", character, last));
        return;
      end
      want = expected_chars.pop_front();
      if (character !== want.character)
        report($sformatf("character 0x%02h, expected 0x%02h", character, want.character));
      if (last !== want.last)
        report($sformatf("last %0b, expected %0b", last, want.last));
    endtask

    function int pending();
      return expected_chars.size();
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst_n;
  logic               start;
  logic               busy;
  logic signed [31:0] in_value;
  logic               out_valid;
  logic [7:0]         out_character;
  logic               out_last;

  decimal_text_board board = new();
  int quiet_cycles = 0;

  signed_int_to_decimal_ascii DUT (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_value(in_value),
    .out_valid(out_valid),
    .out_character(out_character),
    .out_last(out_last)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n && out_valid) board.check_char(out_character, out_last);
  end

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles + 1 >= QUIET_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  task automatic send_word(input logic [31:0] v);
    start    <= 1'b1;
    in_value <= v;
    do @(posedge clk); while (busy);
    board.note_word(v);
  endtask

  task automatic pause_start(input int cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
  endtask

  initial begin
    logic [31:0] directed[] = '{
      32'd0, 32'd1, -32'sd1, 32'd9, -32'sd9, 32'd10, -32'sd10, 32'd99, 32'd100,
      -32'sd100, 32'd12345, -32'sd67890, 32'd999999999, 32'd1000000000,
      -32'sd1000000000, 32'h7FFFFFFF, 32'h80000001, 32'h80000000, 32'h7FFFFFFE,
      32'd1234567890, -32'sd1234567890, 32'hFFFFFFFE
    };
    logic [31:0] v;
    logic [31:0] p;
    int          kind;
    int          idle_mode;

    rst_n    <= 1'b0;
    start    <= 1'b0;
    in_value <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed[i]) begin
      send_word(directed[i]);
      if (i % 3 == 1) pause_start($urandom_range(1, 11));
    end
    wait_drained();

    idle_mode = 0;
    for (int n = 0; n < NUM_RANDOM; n++) begin
      if (n % 25 == 0) idle_mode = $urandom_range(0, 2);
      if (n % 150 == 75) wait_drained();
      kind = $urandom_range(0, 4);
      p = 32'd1;
      repeat ($urandom_range(0, 9)) p = p * 32'd10;
      case (kind)
        0, 1: v = $urandom;
        2: v = $urandom_range(0, 99);
        3: v = p + $urandom_range(0, 2) - 32'd1;
        default: v = $urandom_range(0, p * 32'd10 - 32'd1);
      endcase
      if (kind >= 2 && $urandom_range(0, 1)) v = 32'd0 - v;
      send_word(v);
      if (n < NUM_RANDOM - CALM_TAIL) begin
        if ((idle_mode == 1 && $urandom_range(0, 3) == 0) ||
            (idle_mode == 2 && $urandom_range(0, 3) != 0))
          pause_start($urandom_range(1, 11));
      end
    end

    wait_drained();
    repeat (DRAIN_WAIT) @(posedge clk);
    if (board.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule
